### hw/rtl/twis_pkg.sv
// Shared sizes, field widths and status codes for the trie word insert/search block.
package twis_pkg;

    localparam int NODE_COUNT    = 1024;
    localparam int ALPHABET_SIZE = 26;

    localparam int NODE_W      = $clog2(NODE_COUNT);
    localparam int POOL_W      = $clog2(NODE_COUNT + 1);
    localparam int SYM_W       = $clog2(ALPHABET_SIZE);
    localparam int CHILD_DEPTH = NODE_COUNT * ALPHABET_SIZE;
    localparam int SLOT_W      = $clog2(CHILD_DEPTH);

    localparam int LETTER_W   = 5;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 8;
    localparam int STATUS_W   = 2;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_POOL_FULL = 2'd3
    } status_t;

endpackage

### hw/rtl/trie_word_insert_search.sv
// Top level: trie dictionary, letter-serial insert and search over a node table in RAM.
//
//   Channel  Dir  Ports                         Beat
//   s_       in   tvalid tready tdata tuser tlast  one letter of a word
//   m_       out  tvalid tready tdata              one status per word
//
// Each letter is a child-table read, then allocate/write and cursor update.
// The last beat of a word adds the word-end mark read and update.
// After reset a clearing pass over all NODE_COUNT*ALPHABET_SIZE slots (26624) zeroes the
// child table and end marks; s_tready stays low meanwhile.
// Input is taken while a status waits on m_; the next status holds until m_ drains.
module trie_word_insert_search
    import twis_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [4:0] letter, [5] has_letter, [7:6] zero
    input  logic                 s_tuser,   // [0] op
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [1:0] status, [7:2] zero
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_STEP,
        S_MARK_RD,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   clr_reg, clr_next;
    logic [NODE_W-1:0]   cursor_reg, cursor_next;
    logic [POOL_W-1:0]   free_reg, free_next;
    logic                failed_reg, failed_next;
    logic                m_valid_reg, m_valid_next;
    status_t             status_reg, status_next;
    op_t                 op_reg, op_next;
    logic                last_reg, last_next;
    logic                has_reg, has_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;

    logic [LETTER_W-1:0] letter_in;
    logic [SYM_W-1:0]    sym;
    logic                accept;

    logic                child_we;
    logic [SLOT_W-1:0]   child_waddr;
    logic [NODE_W-1:0]   child_wdata;
    logic [NODE_W-1:0]   child_rdata;
    logic                mark_we;
    logic [NODE_W-1:0]   mark_waddr;
    logic                mark_wdata;
    logic                mark_rdata;

    twis_ram #(.WIDTH(NODE_W), .DEPTH(CHILD_DEPTH)) u_child_ram (
        .aclk  (aclk),
        .we    (child_we),
        .waddr (child_waddr),
        .wdata (child_wdata),
        .raddr (slot_next),
        .rdata (child_rdata)
    );

    twis_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_mark_ram (
        .aclk  (aclk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (cursor_reg),
        .rdata (mark_rdata)
    );

    assign letter_in = s_tdata[LETTER_W-1:0];
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(M_TDATA_W-STATUS_W){1'b0}}, status_reg};

    always_comb begin
        if (int'(letter_in) >= ALPHABET_SIZE) begin
            sym = SYM_W'(ALPHABET_SIZE - 1);
        end else begin
            sym = SYM_W'(letter_in);
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        cursor_next  = cursor_reg;
        free_next    = free_reg;
        failed_next  = failed_reg;
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        op_next      = op_reg;
        last_next    = last_reg;
        has_next     = has_reg;
        slot_next    = slot_reg;
        child_we     = 1'b0;
        child_waddr  = slot_reg;
        child_wdata  = free_reg[NODE_W-1:0];
        mark_we      = 1'b0;
        mark_waddr   = cursor_reg;
        mark_wdata   = 1'b1;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                child_we    = 1'b1;
                child_waddr = clr_reg;
                child_wdata = '0;
                mark_we     = 1'b1;
                mark_waddr  = clr_reg[NODE_W-1:0];
                mark_wdata  = 1'b0;
                clr_next    = clr_reg + SLOT_W'(1);
                if (clr_reg == SLOT_W'(CHILD_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    op_next    = op_t'(s_tuser);
                    last_next  = s_tlast;
                    has_next   = s_tdata[LETTER_W];
                    slot_next  = SLOT_W'(SLOT_W'(cursor_reg) * SLOT_W'(ALPHABET_SIZE))
                               + SLOT_W'(sym);
                    state_next = S_STEP;
                end
            end
            S_STEP: begin
                if (has_reg && !failed_reg) begin
                    if (child_rdata != '0) begin
                        cursor_next = child_rdata;
                    end else if (op_reg == OP_SEARCH) begin
                        failed_next = 1'b1;
                    end else if (free_reg == POOL_W'(NODE_COUNT)) begin
                        failed_next = 1'b1;
                    end else begin
                        child_we    = 1'b1;
                        cursor_next = free_reg[NODE_W-1:0];
                        free_next   = free_reg + POOL_W'(1);
                    end
                end
                state_next = last_reg ? S_MARK_RD : S_IDLE;
            end
            S_MARK_RD: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    if (op_reg == OP_INSERT) begin
                        if (failed_reg) begin
                            status_next = ST_POOL_FULL;
                        end else begin
                            mark_we     = 1'b1;
                            status_next = ST_INSERTED;
                        end
                    end else begin
                        status_next = (!failed_reg && mark_rdata) ? ST_FOUND : ST_NOT_FOUND;
                    end
                    m_valid_next = 1'b1;
                    cursor_next  = '0;
                    failed_next  = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            cursor_reg  <= '0;
            free_reg    <= POOL_W'(1);
            failed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            cursor_reg  <= cursor_next;
            free_reg    <= free_next;
            failed_reg  <= failed_next;
            m_valid_reg <= m_valid_next;
        end
        status_reg <= status_next;
        op_reg     <= op_next;
        last_reg   <= last_next;
        has_reg    <= has_next;
        slot_reg   <= slot_next;
    end

endmodule

### hw/rtl/twis_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module twis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
